>>> rtl/bfa_pkg.sv
// Package for the best-fit block allocator.
// Holds sizes, field widths, command codes and the region table entry type.
// No dependencies.
package bfa_pkg;

  localparam int MEM_UNITS     = 1024;
  localparam int TABLE_ENTRIES = 64;

  localparam int TAG_W   = 32;
  localparam int SIZE_W  = 11;
  localparam int START_W = 10;
  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
    logic               used;
    logic [TAG_W-1:0]   owner;
  } region_t;

  localparam int ENTRY_W = $bits(region_t);

endpackage

>>> rtl/bfa_if.sv
// Request and result channels of the best-fit block allocator.
// Depends on bfa_pkg for the field widths.
interface bfa_in_if import bfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [TAG_W-1:0]   owner_tag;
  logic [SIZE_W-1:0]  request_size;

  modport source (output valid, kind, owner_tag, request_size, input ready);
  modport sink   (input valid, kind, owner_tag, request_size, output ready);
endinterface

interface bfa_out_if import bfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               ok;
  logic [START_W-1:0] granted_start;

  modport source (output valid, ok, granted_start, input ready);
  modport sink   (input valid, ok, granted_start, output ready);
endinterface

>>> rtl/best_fit_block_allocator.sv
// Best-fit block allocator: region table in one RAM, scanned one entry a cycle.
// Depends on bfa_pkg, bfa_if (bfa_in_if, bfa_out_if) and bfa_ram.
//
//   channel  dir  payload                          moves
//   in_ch    in   kind, owner_tag, request_size     one request item
//   out_ch   out  ok, granted_start                 one result item per request
//
// A request scans the n live entries of the table (at most 64): the table RAM is
// read one entry per cycle. It then writes the entry found, if any, and an allocation
// that splits a region also writes the remainder. An allocate of size zero skips the scan.
// After reset, the S_INIT state writes the initial free region before any item is taken.
// The result waits in an output register; the next item is accepted meanwhile,
// and a finished result waits for the register to empty before it is loaded.
module best_fit_block_allocator import bfa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  bfa_in_if.sink     in_ch,
  bfa_out_if.source  out_ch
);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_UPD   = 6'b001000,
    S_SPLIT = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   issue_r, issue_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               kind_r, kind_nxt;
  logic [TAG_W-1:0]   tag_r, tag_nxt;
  logic [SIZE_W-1:0]  want_r, want_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   best_idx_r, best_idx_nxt;
  region_t            best_r, best_nxt;
  logic               res_ok_r, res_ok_nxt;
  logic [START_W-1:0] res_start_r, res_start_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [START_W-1:0] out_start_r, out_start_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  region_t            ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  region_t            rd;
  logic               hit;
  logic               in_fire;

  bfa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd        = region_t'(ram_rdata);
  assign ram_raddr = issue_r[IDX_W-1:0];
  assign in_fire   = in_ch.valid && in_ch.ready;

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.ok            = out_ok_r;
  assign out_ch.granted_start = out_start_r;

  always_comb begin
    if (kind_r == KIND_ALLOC) begin
      hit = !rd.used && (rd.size >= want_r) && (!found_r || (rd.size < best_r.size));
    end else begin
      hit = rd.used && (rd.owner == tag_r) && !found_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    issue_nxt     = issue_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = issue_r[IDX_W-1:0];
    kind_nxt      = kind_r;
    tag_nxt       = tag_r;
    want_nxt      = want_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_nxt      = best_r;
    res_ok_nxt    = res_ok_r;
    res_start_nxt = res_start_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_ok_nxt    = out_ok_r;
    out_start_nxt = out_start_r;
    ram_we        = 1'b0;
    ram_waddr     = best_idx_r;
    ram_wdata     = best_r;

    case (state_r)
      S_INIT: begin
        ram_we          = 1'b1;
        ram_waddr       = '0;
        ram_wdata.start = '0;
        ram_wdata.size  = SIZE_W'(MEM_UNITS);
        ram_wdata.used  = 1'b0;
        ram_wdata.owner = '0;
        state_nxt       = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt      = in_ch.kind;
          tag_nxt       = in_ch.owner_tag;
          want_nxt      = in_ch.request_size;
          n_nxt         = count_r;
          issue_nxt     = '0;
          found_nxt     = 1'b0;
          res_ok_nxt    = 1'b0;
          res_start_nxt = '0;
          if ((in_ch.kind == KIND_ALLOC) && (in_ch.request_size == '0)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cmp_vld_r && hit) begin
          found_nxt    = 1'b1;
          best_idx_nxt = cmp_idx_r;
          best_nxt     = rd;
        end
        if (issue_r == n_r) begin
          state_nxt = S_UPD;
        end else begin
          issue_nxt   = issue_r + 1'b1;
          cmp_vld_nxt = 1'b1;
        end
      end
      S_UPD: begin
        state_nxt = S_DONE;
        if (found_r) begin
          ram_we     = 1'b1;
          res_ok_nxt = 1'b1;
          if (kind_r == KIND_ALLOC) begin
            ram_wdata.size  = want_r;
            ram_wdata.used  = 1'b1;
            ram_wdata.owner = tag_r;
            res_start_nxt   = best_r.start;
            if ((best_r.size > want_r) && (n_r < CNT_W'(TABLE_ENTRIES))) begin
              state_nxt = S_SPLIT;
            end
          end else begin
            ram_wdata.used = 1'b0;
          end
        end
      end
      S_SPLIT: begin
        ram_we          = 1'b1;
        ram_waddr       = n_r[IDX_W-1:0];
        ram_wdata.start = best_r.start + want_r[START_W-1:0];
        ram_wdata.size  = best_r.size - want_r;
        ram_wdata.used  = 1'b0;
        ram_wdata.owner = tag_r;
        count_nxt       = n_r + 1'b1;
        state_nxt       = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_start_nxt = res_start_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      count_r     <= CNT_W'(1);
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    issue_r     <= issue_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    kind_r      <= kind_nxt;
    tag_r       <= tag_nxt;
    want_r      <= want_nxt;
    best_idx_r  <= best_idx_nxt;
    best_r      <= best_nxt;
    res_ok_r    <= res_ok_nxt;
    res_start_r <= res_start_nxt;
    out_ok_r    <= out_ok_nxt;
    out_start_r <= out_start_nxt;
  end

`ifndef ASSERT_OFF
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(1)) && (count_r <= CNT_W'(TABLE_ENTRIES)))
    else $error("region count out of range");

  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r >= $past(count_r)))
    else $error("region count decreased");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside completion");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == S_INIT) || (state_r == S_UPD) || (state_r == S_SPLIT)))
    else $error("table write during scan or idle");
`endif

endmodule

>>> rtl/bfa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> dv/best_fit_block_allocator_test.sv
`timescale 1ns / 100ps
// Self-checking bench for best_fit_block_allocator: allocate and free items in,
// one grant or release item out, checked against a region table kept here.
// Depends on bfa_pkg and the bfa_in_if / bfa_out_if interfaces.
module best_fit_block_allocator_test;
  import bfa_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 432;

  typedef struct {
    logic               kind;
    logic [TAG_W-1:0]   tag;
    logic [SIZE_W-1:0]  size;
    bit                 wait_idle;
  } request_t;

  typedef struct {
    logic               ok;
    logic [START_W-1:0] granted_start;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bfa_in_if  in_ch ();
  bfa_out_if out_ch ();

  best_fit_block_allocator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  logic [START_W-1:0] tab_start [TABLE_ENTRIES];
  logic [SIZE_W-1:0]  tab_size  [TABLE_ENTRIES];
  logic               tab_used  [TABLE_ENTRIES];
  logic [TAG_W-1:0]   tab_owner [TABLE_ENTRIES];
  int                 tab_count;

  request_t           pending_requests [$];
  grant_t             expected_grants [$];
  logic [TAG_W-1:0]   tag_pool [16];

  int  accepted_items = 0;
  int  results_seen = 0;
  int  err_count = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  stall_cycles = 0;
  logic calm;

  assign calm = accepted_items >= 250 && accepted_items < 330;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic void add_request(input logic kind, input logic [TAG_W-1:0] tag,
                                      input int size, input bit wait_idle);
    request_t r;
    r.kind      = kind;
    r.tag       = tag;
    r.size      = SIZE_W'(size);
    r.wait_idle = wait_idle;
    pending_requests.push_back(r);
  endfunction

  function automatic grant_t predict_grant(input logic kind, input logic [TAG_W-1:0] tag,
                                           input logic [SIZE_W-1:0] size);
    grant_t g;
    int best;
    int n;
    logic [SIZE_W-1:0] fit_size;
    g.ok = 1'b0;
    g.granted_start = '0;
    best = -1;
    fit_size = '0;
    n = tab_count;
    if (kind == KIND_ALLOC) begin
      if (size != 0) begin
        for (int i = 0; i < n; i++) begin
          if (!tab_used[i] && tab_size[i] >= size && (best < 0 || tab_size[i] < fit_size)) begin
            best = i;
            fit_size = tab_size[i];
          end
        end
      end
      if (best >= 0) begin
        g.ok = 1'b1;
        g.granted_start = tab_start[best];
        tab_owner[best] = tag;
        if (fit_size > size) begin
          if (n < TABLE_ENTRIES) begin
            tab_start[n] = START_W'(tab_start[best] + size);
            tab_size[n]  = fit_size - size;
            tab_used[n]  = 1'b0;
            tab_count    = n + 1;
          end
          tab_size[best] = size;
        end
        tab_used[best] = 1'b1;
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        if (tab_used[i] && tab_owner[i] == tag) begin
          tab_used[i] = 1'b0;
          g.ok = 1'b1;
          break;
        end
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin
    request_t nxt;
    logic take;
    logic send;
    if (!rst_n) begin
      in_ch.valid        <= 1'b0;
      in_ch.kind         <= KIND_ALLOC;
      in_ch.owner_tag    <= '0;
      in_ch.request_size <= '0;
    end else begin
      take = in_ch.valid && in_ch.ready;
      if (take) begin
        expected_grants.push_back(predict_grant(in_ch.kind, in_ch.owner_tag,
                                                in_ch.request_size));
        accepted_items <= accepted_items + 1;
      end
      if (!in_ch.valid || take) begin
        send = pending_requests.size() != 0 && (calm || $urandom_range(99) >= 32);
        if (send && pending_requests[0].wait_idle && (take || accepted_items != results_seen)) begin
          send = 1'b0;
        end
        if (send) begin
          nxt = pending_requests.pop_front();
          in_ch.kind         <= nxt.kind;
          in_ch.owner_tag    <= nxt.tag;
          in_ch.request_size <= nxt.size;
        end
        in_ch.valid <= send;
      end
    end
  end

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_grants.size() == 0) begin
          report_mismatch("result item arrived with no request outstanding");
        end else begin
          want = expected_grants.pop_front();
          if (out_ch.ok !== want.ok) begin
            report_mismatch($sformatf("ok got %b, expected %b", out_ch.ok, want.ok));
          end
          if (out_ch.granted_start !== want.granted_start) begin
            report_mismatch($sformatf("granted_start got %0d, expected %0d",
                                      out_ch.granted_start, want.granted_start));
          end
        end
      end
      out_ch.ready <= hold_left == 0 && (calm || $urandom_range(99) >= 32);
    end
  end

  // The receiver stops once, long enough for the block to back up to its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_items >= 120) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int roll;
    int pick;
    logic [TAG_W-1:0] tag;

    tab_count    = 1;
    tab_start[0] = '0;
    tab_size[0]  = SIZE_W'(MEM_UNITS);
    tab_used[0]  = 1'b0;

    add_request(KIND_ALLOC, 32'hFFFF_FFFF, 0, 1'b0);
    add_request(KIND_ALLOC, 32'hA5A5_0001, MEM_UNITS, 1'b0);
    add_request(KIND_ALLOC, 32'h5A5A_0002, 1, 1'b0);
    add_request(KIND_FREE, 32'h5A5A_0002, MEM_UNITS, 1'b0);
    add_request(KIND_FREE, 32'hA5A5_0001, 0, 1'b0);
    add_request(KIND_ALLOC, 32'h0000_0000, 1, 1'b0);
    add_request(KIND_ALLOC, 32'h1234_5678, MEM_UNITS, 1'b0);
    add_request(KIND_ALLOC, 32'h0000_0000, MEM_UNITS - 1, 1'b0);
    add_request(KIND_FREE, 32'h0000_0000, 555, 1'b0);
    add_request(KIND_FREE, 32'h0000_0000, 0, 1'b0);
    add_request(KIND_ALLOC, 32'h0000_00C3, 1, 1'b0);
    add_request(KIND_FREE, 32'h0000_00C3, 1, 1'b0);
    add_request(KIND_ALLOC, 32'h0000_0D00, 4, 1'b0);
    add_request(KIND_ALLOC, 32'h0000_0E00, 4, 1'b0);
    add_request(KIND_FREE, 32'h0000_0D00, 4, 1'b0);
    add_request(KIND_FREE, 32'h0000_0E00, 4, 1'b0);
    add_request(KIND_ALLOC, 32'h8000_000F, 3, 1'b0);
    add_request(KIND_FREE, 32'h8000_000F, 2047 & MEM_UNITS, 1'b0);

    // Small requests dominate so that the table fills and splits start losing remainders.
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 16; i++) begin
      tag_pool[i] = $urandom();
    end
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      tag = ($urandom_range(99) < 8) ? TAG_W'($urandom()) : tag_pool[$urandom_range(15)];
      roll = $urandom_range(99);
      if (roll < 52) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          add_request(KIND_ALLOC, tag, 0, k == 0 || k == 200);
        end else if (pick < 70) begin
          add_request(KIND_ALLOC, tag, $urandom_range(16, 1), k == 0 || k == 200);
        end else if (pick < 92) begin
          add_request(KIND_ALLOC, tag, $urandom_range(128, 17), k == 0 || k == 200);
        end else begin
          add_request(KIND_ALLOC, tag, $urandom_range(MEM_UNITS, 129), k == 0 || k == 200);
        end
      end else begin
        add_request(KIND_FREE, tag, $urandom_range(MEM_UNITS), k == 0 || k == 200);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_ch.valid || accepted_items != results_seen) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (err_count == 0 && expected_grants.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
